// ===== design/mma_pkg.sv =====
// package for the multichannel moving average unit
// widths, payload types and control structs shared by every design file
// no dependencies
`default_nettype none

package mma_pkg;

	// sizing
	localparam int CHANNELS        = 16;
	localparam int MAX_WINDOW_LOG2 = 8;
	localparam int SAMPLE_BITS     = 16;

	localparam int CH_W    = 4;                                  // channel field width
	localparam int CFG_W   = 4;                                  // window_shift register width
	localparam int IDX_W   = MAX_WINDOW_LOG2;                    // ring position width
	localparam int ADDR_W  = CH_W + IDX_W;                       // window store address
	localparam int SUM_W   = SAMPLE_BITS + MAX_WINDOW_LOG2;      // running sum width
	localparam int SHIFT_W = $clog2(MAX_WINDOW_LOG2 + 1);        // saturated shift width
	localparam int WIN_DEPTH = CHANNELS * (1 << MAX_WINDOW_LOG2);

	localparam logic [CFG_W-1:0] SHIFT_RESET = CFG_W'(3);

	typedef logic        [CH_W-1:0]        ch_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic        [IDX_W-1:0]       idx_t;
	typedef logic        [ADDR_W-1:0]      addr_t;
	typedef logic        [SHIFT_W-1:0]     shift_t;
	typedef logic        [CFG_W-1:0]       cfg_t;

	// per-channel record kept in the channel ram
	typedef struct packed {
		sum_t    sum;
		sample_t prime;
	} chan_rec_t;

	// what the control logic decides for one sample at issue
	typedef struct packed {
		logic   first;    // channel not primed yet, this sample primes it
		logic   filling;  // ring not wrapped since priming
		addr_t  slot;     // window store entry to read and overwrite
		shift_t shift;    // effective window exponent
	} issue_t;

	// bypass selects for the stage that follows the ram reads
	typedef struct packed {
		logic rec;  // channel record was written at the read edge
		logic win;  // window slot was written at the read edge
	} fwd_sel_t;

endpackage

`default_nettype wire

// ===== design/mma_ifs.sv =====
// valid/ready channel interfaces for samples in and averages out
// depends on mma_pkg
`default_nettype none

interface mma_in_if;
	logic                 valid;
	logic                 ready;
	mma_pkg::ch_t         channel;
	mma_pkg::sample_t     sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if;
	logic                 valid;
	logic                 ready;
	mma_pkg::ch_t         channel_out;
	mma_pkg::sample_t     average;

	modport source (output valid, output channel_out, output average, input ready);
	modport sink   (input valid, input channel_out, input average, output ready);
endinterface

`default_nettype wire

// ===== design/mma_ctrl.sv =====
// per-channel ring control: window exponent, primed and filling flags, ring positions
// depends on mma_pkg
`default_nettype none

module mma_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire mma_pkg::cfg_t       cfg_wdata,
	input  wire logic                issue,
	input  wire mma_pkg::ch_t        channel,
	output mma_pkg::issue_t          info
);

	mma_pkg::shift_t shift_q;
	logic [mma_pkg::CHANNELS-1:0] primed_q;
	logic [mma_pkg::CHANNELS-1:0] filling_q;
	mma_pkg::idx_t widx_q [mma_pkg::CHANNELS];

	mma_pkg::idx_t   mask;
	mma_pkg::idx_t   cur_idx;
	mma_pkg::idx_t   next_idx;
	mma_pkg::shift_t shift_sat;

	// ring mask for the current window length
	assign mask     = ~(mma_pkg::idx_t'('1) << shift_q);
	assign cur_idx  = primed_q[channel] ? (widx_q[channel] & mask) : '0;
	assign next_idx = (cur_idx + mma_pkg::idx_t'(1)) & mask;

	// exponents above MAX_WINDOW_LOG2 saturate to it
	assign shift_sat = (int'(cfg_wdata) > mma_pkg::MAX_WINDOW_LOG2)
		? mma_pkg::shift_t'(mma_pkg::MAX_WINDOW_LOG2)
		: mma_pkg::shift_t'(cfg_wdata);

	// decision for the sample at the input
	always_comb begin
		info.first   = ~primed_q[channel];
		info.filling = filling_q[channel];
		info.slot    = {channel, cur_idx};
		info.shift   = shift_q;
	end

	// flag and position update, config write unprimes every channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= mma_pkg::shift_t'(mma_pkg::SHIFT_RESET);
			primed_q  <= '0;
			filling_q <= '0;
			for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
				widx_q[i] <= '0;
			end
		end else if (cfg_we) begin
			shift_q   <= shift_sat;
			primed_q  <= '0;
			filling_q <= '0;
		end else if (issue) begin
			if (!primed_q[channel]) begin
				primed_q[channel]  <= 1'b1;
				filling_q[channel] <= 1'b1;
				widx_q[channel]    <= '0;
			end else begin
				widx_q[channel] <= next_idx;
				if (next_idx == '0) begin
					filling_q[channel] <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mma_state_mem.sv =====
// window store and channel record rams, registered reads
// depends on mma_pkg
`default_nettype none

module mma_state_mem (
	input  wire logic                clk,
	input  wire logic                rd_en,
	input  wire mma_pkg::addr_t      win_rd_addr,
	input  wire mma_pkg::ch_t        rec_rd_addr,
	input  wire logic                win_we,
	input  wire mma_pkg::addr_t      win_wr_addr,
	input  wire mma_pkg::sample_t    win_wr_data,
	input  wire logic                rec_we,
	input  wire mma_pkg::ch_t        rec_wr_addr,
	input  wire mma_pkg::chan_rec_t  rec_wr_data,
	output mma_pkg::sample_t         win_rd_data,
	output mma_pkg::chan_rec_t       rec_rd_data
);

	mma_pkg::sample_t   win_mem [mma_pkg::WIN_DEPTH];
	mma_pkg::chan_rec_t rec_mem [mma_pkg::CHANNELS];

	mma_pkg::sample_t   win_rd_q;
	mma_pkg::chan_rec_t rec_rd_q;

	// window store, read data holds while no sample issues
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wr_addr] <= win_wr_data;
		end
		if (rd_en) begin
			win_rd_q <= win_mem[win_rd_addr];
		end
	end

	// running sum and priming value per channel
	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_wr_addr] <= rec_wr_data;
		end
		if (rd_en) begin
			rec_rd_q <= rec_mem[rec_rd_addr];
		end
	end

	assign win_rd_data = win_rd_q;
	assign rec_rd_data = rec_rd_q;

endmodule

`default_nettype wire

// ===== design/mma_accum.sv =====
// sum update stage: bypass from the last write, add and subtract, floor shift
// depends on mma_pkg
`default_nettype none

module mma_accum (
	input  wire logic                clk,
	input  wire mma_pkg::sample_t    sample,
	input  wire mma_pkg::issue_t     info,
	input  wire mma_pkg::fwd_sel_t   fwd,
	input  wire mma_pkg::chan_rec_t  rd_rec,
	input  wire mma_pkg::sample_t    rd_win,
	input  wire logic                wr_en,
	output mma_pkg::chan_rec_t       rec_new,
	output mma_pkg::sample_t         average
);

	mma_pkg::chan_rec_t fwd_rec_q;
	mma_pkg::sample_t   fwd_win_q;

	mma_pkg::chan_rec_t rec_old;
	mma_pkg::sample_t   win_old;
	mma_pkg::sample_t   leaving;
	mma_pkg::sum_t      sample_ext;
	mma_pkg::sum_t      sum_shr;

	// copy of the last write, used when the ram read raced it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_rec_q <= rec_new;
			fwd_win_q <= sample;
		end
	end

	assign rec_old    = fwd.rec ? fwd_rec_q : rd_rec;
	assign win_old    = fwd.win ? fwd_win_q : rd_win;
	assign leaving    = info.filling ? rec_old.prime : win_old;
	assign sample_ext = mma_pkg::sum_t'(sample);

	// priming fills the window with the sample, else swap leaving for new
	always_comb begin
		if (info.first) begin
			rec_new.sum   = sample_ext <<< info.shift;
			rec_new.prime = sample;
		end else begin
			rec_new.sum   = rec_old.sum + sample_ext - mma_pkg::sum_t'(leaving);
			rec_new.prime = rec_old.prime;
		end
	end

	// mean rounded toward minus infinity
	assign sum_shr = rec_new.sum >>> info.shift;
	assign average = sum_shr[mma_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/multichannel_moving_average_unit.sv =====
// top level of the per-channel running mean over a power-of-two window
// depends on mma_pkg, mma_ifs, mma_ctrl, mma_state_mem, mma_accum
//
//  port        role    payload
//  samples     sink    channel, sample
//  results     source  channel_out, average
//  cfg_*       write   window_shift (unprimes all channels)
//
// one sample per cycle while not stalled; each result passes the update stage and
// the result register; the window store and channel rams are read at transfer and
// written as the update stage advances; a colliding write is bypassed from a register
// reset clears flags and ring positions at once, the rams are not cleared
// a stalled result holds the update stage, input ready follows that stage
`default_nettype none

module multichannel_moving_average_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mma_in_if.sink               samples,
	mma_out_if.source            results,
	input  wire logic            cfg_we,
	input  wire mma_pkg::cfg_t   cfg_wdata
);

	mma_pkg::issue_t    info;
	mma_pkg::chan_rec_t rd_rec;
	mma_pkg::sample_t   rd_win;
	mma_pkg::chan_rec_t rec_new;
	mma_pkg::sample_t   avg;

	logic               accept;
	logic               issue;
	logic               adv_s1;

	// update stage
	logic               vld_s1;
	mma_pkg::ch_t       ch_s1;
	mma_pkg::sample_t   x_s1;
	mma_pkg::issue_t    info_s1;
	mma_pkg::fwd_sel_t  fwd_s1;

	// result register
	logic               out_vld_q;
	mma_pkg::ch_t       out_ch_q;
	mma_pkg::sample_t   out_avg_q;

	// handshake
	assign adv_s1        = vld_s1 && (!out_vld_q || results.ready);
	assign samples.ready = !vld_s1 || adv_s1;
	assign accept        = samples.valid && samples.ready;
	assign issue         = accept && (int'(samples.channel) < mma_pkg::CHANNELS);

	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.issue     (issue),
		.channel   (samples.channel),
		.info      (info)
	);

	mma_state_mem u_mem (
		.clk         (clk),
		.rd_en       (issue),
		.win_rd_addr (info.slot),
		.rec_rd_addr (samples.channel),
		.win_we      (adv_s1 && !info_s1.first),
		.win_wr_addr (info_s1.slot),
		.win_wr_data (x_s1),
		.rec_we      (adv_s1),
		.rec_wr_addr (ch_s1),
		.rec_wr_data (rec_new),
		.win_rd_data (rd_win),
		.rec_rd_data (rd_rec)
	);

	mma_accum u_accum (
		.clk     (clk),
		.sample  (x_s1),
		.info    (info_s1),
		.fwd     (fwd_s1),
		.rd_rec  (rd_rec),
		.rd_win  (rd_win),
		.wr_en   (adv_s1),
		.rec_new (rec_new),
		.average (avg)
	);

	// update stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (samples.ready) begin
			vld_s1 <= issue;
		end
	end

	// update stage payload and bypass selects against the write at this edge
	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1       <= samples.channel;
			x_s1        <= samples.sample;
			info_s1     <= info;
			fwd_s1.rec  <= adv_s1 && (ch_s1 == samples.channel);
			fwd_s1.win  <= adv_s1 && !info_s1.first && (info_s1.slot == info.slot);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_ch_q  <= ch_s1;
			out_avg_q <= avg;
		end
	end

	assign results.valid       = out_vld_q;
	assign results.channel_out = out_ch_q;
	assign results.average     = out_avg_q;

	// a window slot bypass only comes with a bypass of the same channel record
	a_fwd_win_same_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && fwd_s1.win) |-> fwd_s1.rec)
		else $error("window bypass without channel record bypass");

	// a result is only dropped after its transfer
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_vld_q) |-> $past(results.ready))
		else $error("result dropped without transfer");

	// the first sample after a window write primes its channel
	a_cfg_unprimes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (issue |-> info.first))
		else $error("channel still primed after window write");

endmodule

`default_nettype wire
